// ----- rtl/tlwbc_pkg.sv -----
// Shared types, codes and geometry of the two-level write-back cache.
package tlwbc_pkg;

	localparam int BLOCK_BITS   = 128;
	localparam int L1_IDX_W     = 6;
	localparam int L1_TAG_W     = 6;
	localparam int L2_IDX_W     = 9;
	localparam int L2_TAG_W     = 3;
	localparam int BLK_W        = 12;
	localparam int LAT_W        = 20;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam logic [LAT_W-1:0] LAT_SAT = 20'hFFFFF;
	localparam logic [16:0] MEM_BYTES = 17'd65536;
	localparam logic [16:0] WORD_BYTES = 17'd4;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_L1_RD  = 3'd0,
		CFG_L1_WR  = 3'd1,
		CFG_L2_RD  = 3'd2,
		CFG_L2_WR  = 3'd3,
		CFG_MEM_RD = 3'd4,
		CFG_MEM_WR = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_L1_RD,
		S_L1_CHK,
		S_L2_RD,
		S_L2_CHK,
		S_MEM_WB,
		S_MEM_RD,
		S_MEM_FILL,
		S_L2_XFER,
		S_L1_OP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                valid;
		logic                dirty;
		logic [L2_TAG_W-1:0] tag;
	} l2_meta_t;

endpackage

// ----- rtl/two_level_writeback_cache.sv -----
// Two-level direct-mapped write-back cache with latency accounting.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_stall    | op, byte_address, write_word
// output   | out_valid / out_stall  | read_word, access_latency, total_time, range_error
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// On a miss the sequencer may evict dirty lines at both levels; it walks one memory
// port and one latency adder through each writeback and fill step.
// After reset a clearing pass zeroes the backing memory and the L2 tags; no item is
// taken meanwhile, config writes are.
// A finished item waits in the output register; a new item is taken while it waits.
module two_level_writeback_cache (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [15:0]                     byte_address,
	input  logic [31:0]                     write_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     read_word,
	output logic [tlwbc_pkg::LAT_W-1:0]     access_latency,
	output logic [31:0]                     total_time,
	output logic                            range_error,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlwbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlwbc_pkg::CFG_W-1:0]     cfg_data
);
	import tlwbc_pkg::*;

	// control state
	state_t state_q, state_nxt;
	logic [BLK_W-1:0] clr_cnt_q;
	logic [(1<<L1_IDX_W)-1:0] l1_valid_q, l1_dirty_q;
	logic [31:0] time_q;
	logic out_valid_q;
	logic [CFG_W-1:0] cfg_q [6];

	// item and work registers
	op_t op_q;
	logic [15:0] addr_q;
	logic [31:0] wdata_q;
	logic err_q;
	logic [LAT_W-1:0] spent_q;
	logic [BLK_W-1:0] l2_blk_q;
	logic l2_wr_q;
	logic wb_phase_q;
	logic [BLOCK_BITS-1:0] wbuf_q, l2_buf_q, line_q;
	logic [31:0] rdw_q;
	logic [31:0] read_word_q, total_time_q;
	logic [LAT_W-1:0] lat_out_q;
	logic err_out_q;

	// memories
	logic [L1_TAG_W-1:0]   l1_tag_mem  [1<<L1_IDX_W];
	logic [BLOCK_BITS-1:0] l1_data_mem [1<<L1_IDX_W];
	l2_meta_t              l2_meta_mem [1<<L2_IDX_W];
	logic [BLOCK_BITS-1:0] l2_data_mem [1<<L2_IDX_W];
	logic [BLOCK_BITS-1:0] bk_mem      [1<<BLK_W];
	logic [L1_TAG_W-1:0]   l1_tag_rd_q;
	logic [BLOCK_BITS-1:0] l1_data_rd_q, l2_data_rd_q, bk_rd_q;
	l2_meta_t              l2_meta_rd_q;

	// address split
	logic [L1_IDX_W-1:0] l1_idx;
	logic [L1_TAG_W-1:0] l1_tag;
	logic [BLK_W-1:0] item_blk;
	logic [L2_IDX_W-1:0] l2_idx;
	logic [L2_TAG_W-1:0] l2_tag;
	logic [1:0] woff;
	assign l1_idx   = addr_q[9:4];
	assign l1_tag   = addr_q[15:10];
	assign item_blk = addr_q[15:4];
	assign l2_idx   = l2_blk_q[L2_IDX_W-1:0];
	assign l2_tag   = l2_blk_q[BLK_W-1:L2_IDX_W];
	assign woff     = addr_q[3:2];

	logic in_acc, out_acc, done_go, l1_hit, l2_hit, in_err;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign done_go = !out_valid_q || !out_stall;
	assign l1_hit  = l1_valid_q[l1_idx] && (l1_tag_rd_q == l1_tag);
	assign l2_hit  = l2_meta_rd_q.valid && (l2_meta_rd_q.tag == l2_tag);
	assign in_err  = ({1'b0, byte_address[15:2], 2'b00} + WORD_BYTES) > MEM_BYTES;

	// shared latency adder
	logic [CFG_W-1:0] lat_sel;
	logic [LAT_W:0] lat_sum;
	logic [LAT_W-1:0] lat_sat;
	assign lat_sum = {1'b0, spent_q} + {{(LAT_W+1-CFG_W){1'b0}}, lat_sel};
	assign lat_sat = lat_sum[LAT_W] ? LAT_SAT : lat_sum[LAT_W-1:0];

	// line with the stored word merged in
	logic [BLOCK_BITS-1:0] line_merged;
	always_comb begin
		line_merged = line_q;
		line_merged[32*woff +: 32] = wdata_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: if (&clr_cnt_q) state_nxt = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					if ((op == OP_READ || op == OP_WRITE) && !in_err) state_nxt = S_L1_RD;
					else state_nxt = S_DONE;
				end
			end
			S_L1_RD: state_nxt = S_L1_CHK;
			S_L1_CHK: state_nxt = l1_hit ? S_L1_OP : S_L2_RD;
			S_L2_RD: state_nxt = S_L2_CHK;
			S_L2_CHK: begin
				if (l2_hit) state_nxt = S_L2_XFER;
				else if (l2_meta_rd_q.valid && l2_meta_rd_q.dirty) state_nxt = S_MEM_WB;
				else state_nxt = S_MEM_RD;
			end
			S_MEM_WB: state_nxt = S_MEM_RD;
			S_MEM_RD: state_nxt = S_MEM_FILL;
			S_MEM_FILL: state_nxt = S_L2_XFER;
			S_L2_XFER: state_nxt = wb_phase_q ? S_L2_RD : S_L1_OP;
			S_L1_OP: state_nxt = S_DONE;
			S_DONE: if (done_go) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory enables and adder selection
	logic l1_we, l2_meta_we, l2_data_we, bk_we;
	logic [BLOCK_BITS-1:0] l1_wdata, l2_wdata, bk_wdata;
	l2_meta_t l2_meta_wdata;
	logic [L2_IDX_W-1:0] l2_waddr;
	logic [BLK_W-1:0] bk_waddr;
	always_comb begin
		l1_we = 1'b0;
		l1_wdata = l2_buf_q;
		l2_meta_we = 1'b0;
		l2_data_we = 1'b0;
		l2_meta_wdata = '0;
		l2_wdata = bk_rd_q;
		l2_waddr = l2_idx;
		bk_we = 1'b0;
		bk_wdata = l2_data_rd_q;
		bk_waddr = {l2_meta_rd_q.tag, l2_idx};
		lat_sel = '0;
		case (state_q)
			S_CLEAR: begin
				l2_meta_we = 1'b1;
				l2_waddr = clr_cnt_q[L2_IDX_W-1:0];
				bk_we = 1'b1;
				bk_wdata = '0;
				bk_waddr = clr_cnt_q;
			end
			S_MEM_WB: begin
				bk_we = 1'b1;
				lat_sel = cfg_q[CFG_MEM_WR];
			end
			S_MEM_FILL: begin
				l2_meta_we = 1'b1;
				l2_data_we = 1'b1;
				l2_meta_wdata = '{valid: 1'b1, dirty: 1'b0, tag: l2_tag};
				lat_sel = cfg_q[CFG_MEM_RD];
			end
			S_L2_XFER: begin
				if (l2_wr_q) begin
					l2_meta_we = 1'b1;
					l2_data_we = 1'b1;
					l2_meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: l2_tag};
					l2_wdata = wbuf_q;
					lat_sel = cfg_q[CFG_L2_WR];
				end else begin
					l1_we = 1'b1;
					lat_sel = cfg_q[CFG_L2_RD];
				end
			end
			S_L1_OP: begin
				if (op_q == OP_WRITE) begin
					l1_we = 1'b1;
					l1_wdata = line_merged;
					lat_sel = cfg_q[CFG_L1_WR];
				end else begin
					lat_sel = cfg_q[CFG_L1_RD];
				end
			end
			default: ;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (l1_we) begin
			l1_data_mem[l1_idx] <= l1_wdata;
			l1_tag_mem[l1_idx] <= l1_tag;
		end
		l1_data_rd_q <= l1_data_mem[l1_idx];
		l1_tag_rd_q <= l1_tag_mem[l1_idx];
	end

	always_ff @(posedge clk) begin
		if (l2_meta_we) l2_meta_mem[l2_waddr] <= l2_meta_wdata;
		if (l2_data_we) l2_data_mem[l2_waddr] <= l2_wdata;
		l2_meta_rd_q <= l2_meta_mem[l2_idx];
		l2_data_rd_q <= l2_data_mem[l2_idx];
	end

	always_ff @(posedge clk) begin
		if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
		bk_rd_q <= bk_mem[l2_blk_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			l1_valid_q <= '0;
			l1_dirty_q <= '0;
			time_q <= '0;
			out_valid_q <= 1'b0;
			cfg_q[CFG_L1_RD] <= 16'd1;
			cfg_q[CFG_L1_WR] <= 16'd1;
			cfg_q[CFG_L2_RD] <= 16'd10;
			cfg_q[CFG_L2_WR] <= 16'd10;
			cfg_q[CFG_MEM_RD] <= 16'd100;
			cfg_q[CFG_MEM_WR] <= 16'd100;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_L1_RD:  cfg_q[CFG_L1_RD] <= cfg_data;
					CFG_L1_WR:  cfg_q[CFG_L1_WR] <= cfg_data;
					CFG_L2_RD:  cfg_q[CFG_L2_RD] <= cfg_data;
					CFG_L2_WR:  cfg_q[CFG_L2_WR] <= cfg_data;
					CFG_MEM_RD: cfg_q[CFG_MEM_RD] <= cfg_data;
					CFG_MEM_WR: cfg_q[CFG_MEM_WR] <= cfg_data;
					default: ;
				endcase
			end
			// fill marks the line valid and clean, a store marks it dirty
			if (state_q == S_L2_XFER && !l2_wr_q) begin
				l1_valid_q[l1_idx] <= 1'b1;
				l1_dirty_q[l1_idx] <= 1'b0;
			end
			if (state_q == S_L1_OP && op_q == OP_WRITE) l1_dirty_q[l1_idx] <= 1'b1;
			if (state_q == S_DONE && done_go) begin
				out_valid_q <= 1'b1;
				case (op_q)
					OP_READ, OP_WRITE: if (!err_q) time_q <= time_q + {12'd0, spent_q};
					OP_CLEAR: time_q <= '0;
					default: ;
				endcase
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q <= op_t'(op);
					addr_q <= byte_address;
					wdata_q <= write_word;
					err_q <= in_err;
					spent_q <= '0;
					rdw_q <= '0;
				end
			end
			S_L1_CHK: begin
				line_q <= l1_data_rd_q;
				// evict a dirty victim first, else go straight to the fill
				if (l1_valid_q[l1_idx] && l1_dirty_q[l1_idx]) begin
					wb_phase_q <= 1'b1;
					l2_wr_q <= 1'b1;
					l2_blk_q <= {l1_tag_rd_q, l1_idx};
					wbuf_q <= l1_data_rd_q;
				end else begin
					wb_phase_q <= 1'b0;
					l2_wr_q <= 1'b0;
					l2_blk_q <= item_blk;
				end
			end
			S_L2_CHK: l2_buf_q <= l2_data_rd_q;
			S_MEM_WB: spent_q <= lat_sat;
			S_MEM_FILL: begin
				l2_buf_q <= bk_rd_q;
				spent_q <= lat_sat;
			end
			S_L2_XFER: begin
				spent_q <= lat_sat;
				line_q <= l2_buf_q;
				if (wb_phase_q) begin
					wb_phase_q <= 1'b0;
					l2_wr_q <= 1'b0;
					l2_blk_q <= item_blk;
				end
			end
			S_L1_OP: begin
				spent_q <= lat_sat;
				if (op_q == OP_READ) rdw_q <= line_q[32*woff +: 32];
			end
			S_DONE: begin
				if (done_go) begin
					read_word_q <= rdw_q;
					err_out_q <= err_q;
					case (op_q)
						OP_READ, OP_WRITE: begin
							lat_out_q <= err_q ? '0 : spent_q;
							total_time_q <= err_q ? time_q : time_q + {12'd0, spent_q};
						end
						OP_CLEAR: begin
							lat_out_q <= '0;
							total_time_q <= '0;
						end
						default: begin
							lat_out_q <= '0;
							total_time_q <= time_q;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign in_stall       = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign read_word      = read_word_q;
	assign access_latency = lat_out_q;
	assign total_time     = total_time_q;
	assign range_error    = err_out_q;

	// a dirty L1 line is always a valid one
	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(l1_dirty_q & ~l1_valid_q) == '0)
		else $error("dirty L1 line without valid bit");

	// L1 lines never become invalid once filled
	a_valid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(l1_valid_q) >= $countones($past(l1_valid_q)))
		else $error("L1 valid bit dropped");

	// a finished clear reports a zero counter
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && done_go && op_q == OP_CLEAR) |=> (total_time_q == '0 && time_q == '0))
		else $error("clear left the counter nonzero");

	// the clearing pass runs only once after reset
	a_no_clear_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass reentered");
endmodule

// ----- tb/two_level_writeback_cache_checker.sv -----
// Predictor and scoreboard that watch the channels of the two-level write-back cache.
module two_level_writeback_cache_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [15:0]                     byte_address,
	input  logic [31:0]                     write_word,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [31:0]                     read_word,
	input  logic [tlwbc_pkg::LAT_W-1:0]     access_latency,
	input  logic [31:0]                     total_time,
	input  logic                            range_error,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tlwbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlwbc_pkg::CFG_W-1:0]     cfg_data,
	output int                              fail_count,
	output int                              in_flight
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlwbc_pkg::*;

	typedef struct packed {
		logic [31:0]      word;
		logic [LAT_W-1:0] lat;
		logic [31:0]      total;
		logic             err;
	} access_result_t;

	access_result_t expected_q[$];

	logic [CFG_W-1:0] lat_cfg[6];
	logic             l1_v[64], l1_d[64];
	logic [5:0]       l1_t[64];
	logic [127:0]     l1_b[64];
	logic             l2_v[512], l2_d[512];
	logic [2:0]       l2_t[512];
	logic [127:0]     l2_b[512];
	logic [127:0]     mem_blk[4096];
	logic [31:0]      clock_ctr;
	logic [31:0]      spent;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Move a whole block to or from L2, filling from memory on a miss.
	function automatic logic [127:0] l2_block_move(input logic [15:0] a,
			input logic [127:0] d, input bit wr);
		logic [11:0] blk;
		logic [8:0]  ix;
		blk = a[15:4];
		ix  = blk[8:0];
		if (!(l2_v[ix] && l2_t[ix] == a[15:13])) begin
			if (l2_v[ix] && l2_d[ix]) begin
				mem_blk[{l2_t[ix], ix}] = l2_b[ix];
				spent += lat_cfg[CFG_MEM_WR];
			end
			l2_b[ix] = mem_blk[blk];
			spent += lat_cfg[CFG_MEM_RD];
			l2_v[ix] = 1'b1;
			l2_t[ix] = a[15:13];
			l2_d[ix] = 1'b0;
		end
		if (wr) begin
			l2_b[ix] = d;
			l2_d[ix] = 1'b1;
			spent += lat_cfg[CFG_L2_WR];
		end else begin
			spent += lat_cfg[CFG_L2_RD];
		end
		return l2_b[ix];
	endfunction

	function automatic logic [31:0] l1_word_access(input logic [15:0] a,
			input logic [31:0] d, input bit wr);
		logic [5:0] ix;
		ix = a[9:4];
		if (!(l1_v[ix] && l1_t[ix] == a[15:10])) begin
			if (l1_v[ix] && l1_d[ix])
				void'(l2_block_move({l1_t[ix], ix, 4'b0}, l1_b[ix], 1'b1));
			l1_b[ix] = l2_block_move({a[15:4], 4'b0}, '0, 1'b0);
			l1_v[ix] = 1'b1;
			l1_t[ix] = a[15:10];
			l1_d[ix] = 1'b0;
		end
		if (wr) begin
			l1_b[ix][a[3:2]*32 +: 32] = d;
			l1_d[ix] = 1'b1;
			spent += lat_cfg[CFG_L1_WR];
			return '0;
		end
		spent += lat_cfg[CFG_L1_RD];
		return l1_b[ix][a[3:2]*32 +: 32];
	endfunction

	function automatic access_result_t predict_access(input op_t o, input logic [15:0] a,
			input logic [31:0] d);
		access_result_t r;
		logic [16:0]    start;
		r = '0;
		case (o)
			OP_CLEAR: clock_ctr = '0;
			OP_READ, OP_WRITE: begin
				start = {1'b0, a[15:2], 2'b00};
				if (start + WORD_BYTES > MEM_BYTES) begin
					r.err = 1'b1;
				end else begin
					spent = '0;
					r.word = l1_word_access(a, d, o == OP_WRITE);
					clock_ctr += spent;
					r.lat = (spent > LAT_SAT) ? LAT_SAT : spent[LAT_W-1:0];
				end
			end
			default: ;
		endcase
		r.total = clock_ctr;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			lat_cfg = '{16'd1, 16'd1, 16'd10, 16'd10, 16'd100, 16'd100};
			for (int i = 0; i < 64; i++) begin
				l1_v[i] = 0; l1_d[i] = 0; l1_t[i] = '0; l1_b[i] = '0;
			end
			for (int i = 0; i < 512; i++) begin
				l2_v[i] = 0; l2_d[i] = 0; l2_t[i] = '0; l2_b[i] = '0;
			end
			for (int i = 0; i < 4096; i++) mem_blk[i] = '0;
			clock_ctr = '0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < 6)
				lat_cfg[cfg_index] = cfg_data;
			if (in_valid && !in_stall)
				expected_q.push_back(predict_access(op_t'(op), byte_address, write_word));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", read_word, '0);
				end else begin
					want = expected_q.pop_front();
					if (read_word !== want.word)
						report_mismatch("read_word", read_word, want.word);
					if (access_latency !== want.lat)
						report_mismatch("access_latency", access_latency, want.lat);
					if (total_time !== want.total)
						report_mismatch("total_time", total_time, want.total);
					if (range_error !== want.err)
						report_mismatch("range_error", range_error, want.err);
				end
			end
		end
		in_flight = expected_q.size();
	end

endmodule

// ----- tb/two_level_writeback_cache_tb.sv -----
// Stimulus, clock, reset and verdict for the two-level write-back cache.
module two_level_writeback_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlwbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall;
	logic [1:0]           op;
	logic [15:0]          byte_address;
	logic [31:0]          write_word;
	logic                 out_valid, out_stall;
	logic [31:0]          read_word;
	logic [LAT_W-1:0]     access_latency;
	logic [31:0]          total_time;
	logic                 range_error;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count, in_flight;
	int                   items_sent;
	bit                   calm;   // set while neither side may idle

	two_level_writeback_cache i_dut (.*);

	two_level_writeback_cache_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the run hangs.
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[two_level_writeback_cache] ERROR");
				$finish;
			end
		end
	end

	// Receiver side: random stalls, one long hold-off so the block backs up.
	initial begin
		bit held;
		held = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && items_sent >= 150) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 14);
			end
		end
	end

	// Offer one item; hold it until accepted.
	task automatic send_item(input op_t o, input logic [15:0] a, input logic [31:0] d);
		while (!calm && $urandom_range(0, 99) < 14) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		op           <= o;
		byte_address <= a;
		write_word   <= d;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Leave cfg_valid high between back-to-back writes; caller drops it.
	task automatic write_latency(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain every expected result, then let the sequencer settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_all(input int mode);
		for (int i = 0; i < 6; i++) begin
			case (mode)
				0: write_latency(cfg_idx_t'(i), 16'd0);
				1: write_latency(cfg_idx_t'(i), 16'hFFFF);
				default: write_latency(cfg_idx_t'(i), 16'($urandom));
			endcase
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Addresses mostly crowd a few L1 and L2 sets to force dirty evictions.
	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		a = 16'($urandom);
		if ($urandom_range(0, 99) < 70)
			a[9:4] = 6'($urandom_range(0, 3));
		return a;
	endfunction

	task automatic random_items(input int n);
		int   r;
		op_t  o;
		for (int k = 0; k < n; k++) begin
			calm = (items_sent >= 500 && items_sent < 650);
			r = $urandom_range(0, 99);
			o = (r < 45) ? OP_READ : (r < 90) ? OP_WRITE : (r < 95) ? OP_CLEAR : OP_NONE;
			send_item(o, pick_address(), $urandom);
		end
		calm = 0;
	endtask

	initial begin
		in_valid = 1'b0; op = OP_READ; byte_address = '0; write_word = '0;
		cfg_valid = 1'b0; cfg_index = CFG_L1_RD; cfg_data = '0;
		items_sent = 0; calm = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: cold miss, hits, top word, unaligned, dirty evictions, clear.
		send_item(OP_READ,  16'h0000, 32'h0);
		send_item(OP_WRITE, 16'h0000, 32'hDEADBEEF);
		send_item(OP_READ,  16'h0000, 32'h0);
		send_item(OP_WRITE, 16'hFFFC, 32'hFFFFFFFF);
		send_item(OP_READ,  16'hFFFF, 32'h0);
		send_item(OP_WRITE, 16'h0007, 32'h12345678);
		send_item(OP_READ,  16'h0400, 32'h0);
		send_item(OP_READ,  16'h0004, 32'h0);
		send_item(OP_WRITE, 16'h0400, 32'hA5A5A5A5);
		send_item(OP_READ,  16'h2000, 32'h0);
		send_item(OP_READ,  16'h0000, 32'h0);
		send_item(OP_READ,  16'h0400, 32'h0);
		send_item(OP_CLEAR, 16'hFFFF, 32'hFFFFFFFF);
		send_item(OP_NONE,  16'h1234, 32'h0);
		send_item(OP_WRITE, 16'hE3F0, 32'h00000000);
		send_item(OP_READ,  16'hE3F0, 32'h0);

		random_items(350);
		drain();
		set_all(2);
		random_items(300);
		drain();
		set_all(0);
		random_items(200);
		drain();
		set_all(1);
		random_items(200);
		drain();
		set_all(2);
		random_items(250);
		drain();

		if (fail_count == 0)
			$display("[two_level_writeback_cache] OK");
		else
			$display("[two_level_writeback_cache] ERROR");
		$finish;
	end

endmodule
